[rtl/lwrg_pkg.sv]
// Shared types, codes and pixel classification for the label wavefront block.
package lwrg_pkg;

    localparam int          PIX_W     = 32;
    localparam int          PASS_W    = 17;
    localparam logic [31:0] LABEL_MAX = 32'd65279;
    localparam logic [16:0] PASS_SAT  = 17'd65536;

    // configuration register indexes
    localparam logic CFG_IMAGE_ROWS = 1'b0;
    localparam logic CFG_IMAGE_COLS = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // one pixel as it travels along the window chain
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             lab;
    } cell_t;

    function automatic logic is_label(input logic [PIX_W-1:0] v);
        return (v != '0) && (v[PIX_W-1] || (v <= LABEL_MAX));
    endfunction

    function automatic logic is_unassigned(input logic [PIX_W-1:0] v);
        return !v[PIX_W-1] && (v > LABEL_MAX);
    endfunction

endpackage

[rtl/lwrg_cell.sv]
// One stage of the pixel window chain: holds a pixel and hands it on each shift.
module lwrg_cell
(
    input  logic            clk,
    input  logic            shift_en,
    input  lwrg_pkg::cell_t d,
    output lwrg_pkg::cell_t q
);

    lwrg_pkg::cell_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

[rtl/label_wavefront_region_growing.sv]
// Top level of the label wavefront region growing block.
//
// Usage: items enter on in_valid/in_stall with req_type, pixel_row, pixel_col,
// pixel_in. A write stores one pixel inside the image in use (no result).
// A read gives one result (result_kind 0). A run repeats growing passes
// until one changes nothing, then gives one result (result_kind 1) with the
// pass count. Results leave on out_valid/out_stall through an output register.
// Each pass streams the image from the label memory in raster order, one
// pixel a cycle over all MAX_COLS columns of every row in use, into a chain of
// 2*MAX_COLS+3 cells whose fixed taps form the 3x3 window; grown pixels are
// written back in place behind the window. in_stall is high for the whole run.
// Reset clears the control state and sets both image sizes to 256; the
// pixel memory holds garbage until written. While out_stall is high a
// finished result holds, writes are still taken, and a new read or run
// waits for the output register before it completes.
// Config writes (cfg_we) are taken at any edge, meant only while idle.
module label_wavefront_region_growing
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [7:0]         pixel_row,
    input  logic [7:0]         pixel_col,
    input  logic signed [31:0] pixel_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pixel_out,
    output logic [16:0]        pass_count,
    output logic               result_kind
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int CHAIN = 2 * MAX_COLS + 3;
    // window taps in raster scan order; tap 0 is the oldest pixel
    localparam int TAP [9] = '{2*MAX_COLS+2, 2*MAX_COLS+1, 2*MAX_COLS,
                               MAX_COLS+2,   MAX_COLS+1,   MAX_COLS,
                               2,            1,            0};

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_RD_OUT  = 5'b00010,
        ST_PASS    = 5'b00100,
        ST_DRAIN   = 5'b01000,
        ST_RUN_OUT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]  image_rows_reg, image_cols_reg;
    logic [RW-1:0] rows_use;
    logic [CW-1:0] cols_use;

    // config and sizes in use (clamped)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg <= 9'd256;
            image_cols_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lwrg_pkg::CFG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                lwrg_pkg::CFG_IMAGE_COLS: image_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (image_rows_reg < 9'd3)
            rows_use = RW'(3);
        else if (32'(image_rows_reg) > MAX_ROWS)
            rows_use = RW'(MAX_ROWS);
        else
            rows_use = RW'(image_rows_reg);
        if (image_cols_reg < 9'd3)
            cols_use = CW'(3);
        else if (32'(image_cols_reg) > MAX_COLS)
            cols_use = CW'(MAX_COLS);
        else
            cols_use = CW'(image_cols_reg);
    end

    // input decode
    logic          in_xfer;
    logic          in_image;
    logic [AW-1:0] item_addr;
    logic          item_wr, item_rd, item_run;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign in_image  = (32'(pixel_row) < 32'(rows_use)) && (32'(pixel_col) < 32'(cols_use));
    assign item_addr = AW'(32'(pixel_row) * MAX_COLS + 32'(pixel_col));

    always_comb
    begin
        item_wr  = 1'b0;
        item_rd  = 1'b0;
        item_run = 1'b0;
        case (lwrg_pkg::req_t'(req_type))
            lwrg_pkg::REQ_WRITE: item_wr  = in_xfer;
            lwrg_pkg::REQ_RUN:   item_run = in_xfer;
            lwrg_pkg::REQ_READ:  item_rd  = in_xfer;
            lwrg_pkg::REQ_NONE:  ;
            default: ;
        endcase
    end

    // pass sequencing
    logic [NW-1:0]  rd_cnt_reg, pass_len_reg, ent_cnt_reg;
    logic           rvalid_reg;
    logic [1:0]     drain_cnt_reg;
    logic [RIW-1:0] nr_reg, cur_r_reg;
    logic [CIW-1:0] nc_reg, cur_c_reg;
    logic           eval_reg;
    logic           changed_reg;
    logic           pass_wr_reg;
    logic [AW-1:0]  pass_addr_reg;
    logic [31:0]    pass_data_reg;
    logic [16:0]    pass_cnt_reg, pass_cnt_next;
    logic           rd_inside_reg;
    logic           pass_end, out_free, restart;

    assign out_free      = !out_valid || !out_stall;
    assign pass_end      = (state_reg == ST_DRAIN) && (drain_cnt_reg == 2'd3);
    assign restart       = pass_end && changed_reg;
    assign pass_cnt_next = (pass_cnt_reg == lwrg_pkg::PASS_SAT) ? pass_cnt_reg
                                                                : pass_cnt_reg + 17'd1;

    // label memory
    logic [31:0]   mem [DEPTH];
    logic [31:0]   mem_rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;

    assign mem_we    = (item_wr && in_image) || pass_wr_reg;
    assign mem_waddr = pass_wr_reg ? pass_addr_reg : item_addr;
    assign mem_wdata = pass_wr_reg ? pass_data_reg : 32'(pixel_in);
    assign mem_re    = item_rd || (state_reg == ST_PASS);
    assign mem_raddr = (state_reg == ST_PASS) ? AW'(rd_cnt_reg) : item_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    // window chain
    lwrg_pkg::cell_t chain [CHAIN];
    lwrg_pkg::cell_t head;
    lwrg_pkg::cell_t win [9];

    assign head.pix = mem_rdata_reg;
    assign head.lab = lwrg_pkg::is_label(mem_rdata_reg);

    generate
        for (genvar i = 0; i < CHAIN; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                lwrg_cell u_cell (.clk(clk), .shift_en(rvalid_reg), .d(head), .q(chain[i]));
            end
            else
            begin : g_rest
                lwrg_cell u_cell (.clk(clk), .shift_en(rvalid_reg), .d(chain[i-1]),
                                  .q(chain[i]));
            end
        end
        for (genvar k = 0; k < 9; k++)
        begin : g_tap
            assign win[k] = chain[TAP[k]];
        end
    endgenerate

    // first labelled pixel of the window, raster order
    logic        found;
    logic [31:0] pick;
    logic        interior;
    logic        grow;

    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int k = 0; k < 9; k++)
        begin
            if (!found && win[k].lab)
            begin
                pick  = win[k].pix;
                found = 1'b1;
            end
        end
    end

    assign interior = (cur_r_reg != '0) && (32'(cur_r_reg) + 1 < 32'(rows_use))
                   && (cur_c_reg != '0) && (32'(cur_c_reg) + 1 < 32'(cols_use));
    assign grow     = eval_reg && interior && found
                   && lwrg_pkg::is_unassigned(win[4].pix);

    // pass datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg    <= '0;
            pass_len_reg  <= '0;
            ent_cnt_reg   <= '0;
            rvalid_reg    <= 1'b0;
            drain_cnt_reg <= '0;
            nr_reg        <= '0;
            nc_reg        <= '0;
            cur_r_reg     <= '0;
            cur_c_reg     <= '0;
            eval_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            pass_wr_reg   <= 1'b0;
            pass_cnt_reg  <= '0;
        end
        else
        begin
            rvalid_reg  <= (state_reg == ST_PASS);
            pass_wr_reg <= grow;
            if (grow)
                changed_reg <= 1'b1;

            if (item_run || restart)
            begin
                rd_cnt_reg  <= '0;
                ent_cnt_reg <= '0;
                nr_reg      <= '0;
                nc_reg      <= '0;
                changed_reg <= 1'b0;
            end
            if (item_run)
            begin
                pass_len_reg <= NW'(32'(rows_use) * MAX_COLS);
                pass_cnt_reg <= '0;
            end
            if (pass_end)
                pass_cnt_reg <= pass_cnt_next;

            if (state_reg == ST_PASS)
                rd_cnt_reg <= rd_cnt_reg + NW'(1);

            drain_cnt_reg <= (state_reg == ST_DRAIN) ? drain_cnt_reg + 2'd1 : 2'd0;

            // center of the window follows the stream once the chain is primed
            eval_reg <= 1'b0;
            if (rvalid_reg)
            begin
                ent_cnt_reg <= ent_cnt_reg + NW'(1);
                if (32'(ent_cnt_reg) >= MAX_COLS + 1)
                begin
                    eval_reg  <= 1'b1;
                    cur_r_reg <= nr_reg;
                    cur_c_reg <= nc_reg;
                    if (32'(nc_reg) == MAX_COLS - 1)
                    begin
                        nc_reg <= '0;
                        nr_reg <= nr_reg + RIW'(1);
                    end
                    else
                    begin
                        nc_reg <= nc_reg + CIW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_addr_reg <= AW'(32'(cur_r_reg) * MAX_COLS + 32'(cur_c_reg));
        pass_data_reg <= pick;
        if (item_rd)
            rd_inside_reg <= in_image;
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_rd)
                    state_next = ST_RD_OUT;
                else if (item_run)
                    state_next = ST_PASS;
            end
            ST_RD_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_PASS:
            begin
                if (rd_cnt_reg == pass_len_reg - NW'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pass_end)
                    state_next = changed_reg ? ST_PASS : ST_RUN_OUT;
            end
            ST_RUN_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    logic        out_valid_reg;
    logic [31:0] pixel_out_reg;
    logic [16:0] pass_count_reg;
    logic        kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (((state_reg == ST_RD_OUT) || (state_reg == ST_RUN_OUT)) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RD_OUT) && out_free)
        begin
            pixel_out_reg  <= rd_inside_reg ? mem_rdata_reg : 32'd0;
            pass_count_reg <= '0;
            kind_reg       <= 1'b0;
        end
        else if ((state_reg == ST_RUN_OUT) && out_free)
        begin
            pixel_out_reg  <= '0;
            pass_count_reg <= pass_cnt_reg;
            kind_reg       <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign pass_count  = pass_count_reg;
    assign result_kind = kind_reg;

    // checks
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_grow_marks_change: assert property (@(posedge clk) disable iff (!rst_n)
        pass_wr_reg |-> changed_reg)
        else $error("pixel grown without change flag");

    a_grow_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pass_wr_reg |-> ((state_reg == ST_PASS) || (state_reg == ST_DRAIN)))
        else $error("grow write outside a pass");

    a_run_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind) |-> (pixel_out == 32'sd0))
        else $error("run result carries pixel data");

endmodule
